// ===== sv/cau_pkg.sv =====
`timescale 1ns / 1ps

package cau_pkg;

  localparam int CAU_DW        = 32;
  localparam int CAU_FRAC_BITS = 16;
  localparam int CAU_PW        = 2 * CAU_DW;   // product / radicand width
  localparam int CAU_RW        = CAU_PW + 1;   // partial remainder width
  localparam int CAU_MW        = CAU_PW + 1;   // magnitude width for clamping
  localparam int CAU_CMD_W     = 4;
  localparam int CAU_STS_W     = 2;

  typedef logic signed [CAU_DW-1:0] word_t;
  typedef logic        [CAU_PW-1:0] dword_t;
  typedef logic signed [CAU_PW-1:0] sdword_t;

  typedef enum logic [CAU_CMD_W-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_NEG   = 4'd4,
    CMD_CONJ  = 4'd5,
    CMD_SQRT  = 4'd6,
    CMD_NORM2 = 4'd7,
    CMD_EQUAL = 4'd8
  } cmd_e;

  typedef enum logic [CAU_STS_W-1:0] {
    STS_OK  = 2'd0,
    STS_SAT = 2'd1,
    STS_DZ  = 2'd2
  } sts_e;

  localparam word_t WORD_MAX = {1'b0, {(CAU_DW-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(CAU_DW-1){1'b0}}};

  // One compare-subtract lane: divide step (one bit) or root step (two bits).
  typedef struct packed {
    logic              run;
    logic              sqr;
    logic [CAU_RW-1:0] rem;
    logic [CAU_DW-1:0] acc;
    dword_t            src;
    dword_t            den;
  } lane_t;

  typedef struct packed {
    cmd_e  op;
    word_t ar;
    logic  ai_neg;
    logic  n1;
    logic  n2;
    logic  ovf1;
    logic  ovf2;
    logic  dz;
    logic  sat;
    logic  eq;
    word_t res_re;
    word_t res_im;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    lane_t [1:0] ln;
  } stg_t;

  typedef struct packed {
    word_t res_re;
    word_t res_im;
    logic  is_equal;
    sts_e  status;
  } rsp_t;

  // Sign and magnitude to a saturated word; returns {sat, value}.
  function automatic logic [CAU_DW:0] clamp_mag(input logic neg,
                                               input logic [CAU_MW-1:0] mag);
    logic [CAU_MW-1:0] lim;
    logic [CAU_DW-1:0] v;
    logic              s;
    lim = CAU_MW'(1) << (CAU_DW - 1);
    if (!neg) lim = lim - CAU_MW'(1);
    if (mag > lim) begin
      s = 1'b1;
      v = neg ? WORD_MIN : WORD_MAX;
    end else begin
      s = 1'b0;
      v = neg ? (~mag[CAU_DW-1:0] + CAU_DW'(1)) : mag[CAU_DW-1:0];
    end
    return {s, v};
  endfunction

endpackage

// ===== sv/cau_if.sv =====
`timescale 1ns / 1ps

interface cau_req_if;
  import cau_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CAU_CMD_W-1:0] cmd;
  word_t                a_re;
  word_t                a_im;
  word_t                b_re;
  word_t                b_im;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
  modport mon    (input valid, ready, cmd, a_re, a_im, b_re, b_im);
endinterface

interface cau_rsp_if;
  import cau_pkg::*;
  logic                 valid;
  logic                 ready;
  word_t                res_re;
  word_t                res_im;
  logic                 is_equal;
  logic [CAU_STS_W-1:0] status;

  modport source (output valid, res_re, res_im, is_equal, status, input ready);
  modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
  modport mon    (input valid, ready, res_re, res_im, is_equal, status);
endinterface

// ===== sv/cau_front.sv =====
`timescale 1ns / 1ps

module cau_front #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [cau_pkg::CAU_CMD_W-1:0] cmd_i,
  input  cau_pkg::word_t                a_re_i,
  input  cau_pkg::word_t                a_im_i,
  input  cau_pkg::word_t                b_re_i,
  input  cau_pkg::word_t                b_im_i,
  output logic                          vld_o,
  output cau_pkg::stg_t                 stg_o
);
  import cau_pkg::*;

  localparam int SH_DIV = CAU_DW - FRAC_BITS;

  // product stage
  logic    p_vld_q;
  cmd_e    p_op_q;
  word_t   p_ar_q, p_ai_q, p_br_q, p_bi_q;
  sdword_t p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_sq0_q, p_sq1_q;
  cmd_e    op_in;
  word_t   x0, x1;

  // sum stage
  logic    s_vld_q;
  cmd_e    s_op_q;
  word_t   s_ar_q;
  logic    s_ai_neg_q, s_n1_q, s_n2_q, s_sat_q, s_eq_q;
  dword_t  s_m1_q, s_m2_q, s_sq_q;
  word_t   s_re_q, s_im_q;

  logic signed [CAU_PW:0] s1, s2;
  dword_t                 sq, m1, m2;
  logic [CAU_DW:0]        c_re, c_im;
  logic                   eq;

  // load stage
  logic  l_vld_q;
  stg_t  l_q, l_d;

  function automatic logic [CAU_DW:0] clamp_s(input logic signed [CAU_DW:0] x);
    logic [CAU_DW:0] xa;
    xa = x[CAU_DW] ? unsigned'(-x) : unsigned'(x);
    return clamp_mag(x[CAU_DW], CAU_MW'(xa));
  endfunction

  // floor of a Q(2F) value to Q(F), then saturate
  function automatic logic [CAU_DW:0] floor_sat(input logic neg, input dword_t mag);
    logic [CAU_MW-1:0] t;
    t = CAU_MW'(mag);
    if (neg) t = t + ((CAU_MW'(1) << FRAC_BITS) - CAU_MW'(1));
    return clamp_mag(neg, t >> FRAC_BITS);
  endfunction

  // ---------------- product stage
  assign op_in = cmd_e'(cmd_i);
  assign x0    = (op_in == CMD_DIV) ? b_re_i : a_re_i;
  assign x1    = (op_in == CMD_DIV) ? b_im_i : a_im_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      l_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= vld_i;
      s_vld_q <= p_vld_q;
      l_vld_q <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_op_q  <= op_in;
      p_ar_q  <= a_re_i;
      p_ai_q  <= a_im_i;
      p_br_q  <= b_re_i;
      p_bi_q  <= b_im_i;
      p_rr_q  <= sdword_t'(a_re_i) * sdword_t'(b_re_i);
      p_ii_q  <= sdword_t'(a_im_i) * sdword_t'(b_im_i);
      p_ri_q  <= sdword_t'(a_re_i) * sdword_t'(b_im_i);
      p_ir_q  <= sdword_t'(a_im_i) * sdword_t'(b_re_i);
      p_sq0_q <= sdword_t'(x0) * sdword_t'(x0);
      p_sq1_q <= sdword_t'(x1) * sdword_t'(x1);
    end
  end

  // ---------------- sum stage
  always_comb begin
    sq = dword_t'(p_sq0_q) + dword_t'(p_sq1_q);
    if (p_op_q == CMD_DIV) begin
      s1 = (CAU_PW+1)'(p_rr_q) + (CAU_PW+1)'(p_ii_q);
      s2 = (CAU_PW+1)'(p_ir_q) - (CAU_PW+1)'(p_ri_q);
    end else begin
      s1 = (CAU_PW+1)'(p_rr_q) - (CAU_PW+1)'(p_ii_q);
      s2 = (CAU_PW+1)'(p_ri_q) + (CAU_PW+1)'(p_ir_q);
    end
    m1 = s1[CAU_PW] ? dword_t'(-s1) : dword_t'(s1);
    m2 = s2[CAU_PW] ? dword_t'(-s2) : dword_t'(s2);
    eq = 1'b0;
    c_re = '0;
    c_im = '0;
    unique case (p_op_q)
      CMD_ADD: begin
        c_re = clamp_s((CAU_DW+1)'(p_ar_q) + (CAU_DW+1)'(p_br_q));
        c_im = clamp_s((CAU_DW+1)'(p_ai_q) + (CAU_DW+1)'(p_bi_q));
      end
      CMD_SUB: begin
        c_re = clamp_s((CAU_DW+1)'(p_ar_q) - (CAU_DW+1)'(p_br_q));
        c_im = clamp_s((CAU_DW+1)'(p_ai_q) - (CAU_DW+1)'(p_bi_q));
      end
      CMD_NEG: begin
        c_re = clamp_s(-(CAU_DW+1)'(p_ar_q));
        c_im = clamp_s(-(CAU_DW+1)'(p_ai_q));
      end
      CMD_CONJ: begin
        c_re = {1'b0, p_ar_q};
        c_im = clamp_s(-(CAU_DW+1)'(p_ai_q));
      end
      CMD_EQUAL: eq = (p_ar_q == p_br_q) && (p_ai_q == p_bi_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_op_q     <= p_op_q;
      s_ar_q     <= p_ar_q;
      s_ai_neg_q <= p_ai_q[CAU_DW-1];
      s_n1_q     <= s1[CAU_PW];
      s_n2_q     <= s2[CAU_PW];
      s_m1_q     <= m1;
      s_m2_q     <= m2;
      s_sq_q     <= sq;
      s_re_q     <= c_re[CAU_DW-1:0];
      s_im_q     <= c_im[CAU_DW-1:0];
      s_sat_q    <= c_re[CAU_DW] | c_im[CAU_DW];
      s_eq_q     <= eq;
    end
  end

  // ---------------- load stage: round products, set up the lanes
  always_comb begin
    logic [CAU_DW:0] f1, f2;
    f1 = '0;
    f2 = '0;
    l_d            = '0;
    l_d.ctx.op     = s_op_q;
    l_d.ctx.ar     = s_ar_q;
    l_d.ctx.ai_neg = s_ai_neg_q;
    l_d.ctx.n1     = s_n1_q;
    l_d.ctx.n2     = s_n2_q;
    l_d.ctx.eq     = s_eq_q;
    l_d.ctx.res_re = s_re_q;
    l_d.ctx.res_im = s_im_q;
    l_d.ctx.sat    = s_sat_q;
    unique case (s_op_q)
      CMD_MUL: begin
        f1 = floor_sat(s_n1_q, s_m1_q);
        f2 = floor_sat(s_n2_q, s_m2_q);
        l_d.ctx.res_re = f1[CAU_DW-1:0];
        l_d.ctx.res_im = f2[CAU_DW-1:0];
        l_d.ctx.sat    = f1[CAU_DW] | f2[CAU_DW];
      end
      CMD_NORM2: begin
        f1 = floor_sat(1'b0, s_sq_q);
        l_d.ctx.res_re = f1[CAU_DW-1:0];
        l_d.ctx.sat    = f1[CAU_DW];
      end
      CMD_DIV: begin
        l_d.ctx.dz   = (s_sq_q == '0);
        l_d.ctx.ovf1 = (s_m1_q >> SH_DIV) >= s_sq_q;
        l_d.ctx.ovf2 = (s_m2_q >> SH_DIV) >= s_sq_q;
        l_d.ln[0].run = 1'b1;
        l_d.ln[0].rem = CAU_RW'(s_m1_q >> SH_DIV);
        l_d.ln[0].src = s_m1_q << (CAU_DW + FRAC_BITS);
        l_d.ln[0].den = s_sq_q;
        l_d.ln[1].run = 1'b1;
        l_d.ln[1].rem = CAU_RW'(s_m2_q >> SH_DIV);
        l_d.ln[1].src = s_m2_q << (CAU_DW + FRAC_BITS);
        l_d.ln[1].den = s_sq_q;
      end
      CMD_SQRT: begin
        l_d.ln[0].run = 1'b1;
        l_d.ln[0].sqr = 1'b1;
        l_d.ln[0].src = s_sq_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) l_q <= l_d;
  end

  assign vld_o = l_vld_q;
  assign stg_o = l_q;

endmodule

// ===== sv/cau_cell.sv =====
`timescale 1ns / 1ps

module cau_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  cau_pkg::stg_t stg_i,
  output logic          vld_o,
  output cau_pkg::stg_t stg_o
);
  import cau_pkg::*;

  logic vld_q;
  stg_t stg_q, stg_d;

  // one restoring step: divide takes one dividend bit, root takes two
  function automatic lane_t lane_step(input lane_t l);
    lane_t             o;
    logic [CAU_RW-1:0] rs, t;
    logic [CAU_RW:0]   dif;
    o = l;
    if (l.sqr) begin
      rs    = {l.rem[CAU_RW-3:0], l.src[CAU_PW-1 -: 2]};
      t     = CAU_RW'({l.acc, 2'b01});
      o.src = l.src << 2;
    end else begin
      rs    = {l.rem[CAU_RW-2:0], l.src[CAU_PW-1]};
      t     = CAU_RW'(l.den);
      o.src = l.src << 1;
    end
    dif = {1'b0, rs} - {1'b0, t};
    if (!dif[CAU_RW]) begin
      o.rem = dif[CAU_RW-1:0];
      o.acc = {l.acc[CAU_DW-2:0], 1'b1};
    end else begin
      o.rem = rs;
      o.acc = {l.acc[CAU_DW-2:0], 1'b0};
    end
    if (!l.run) o = l;
    return o;
  endfunction

  always_comb begin
    stg_d       = stg_i;
    stg_d.ln[0] = lane_step(stg_i.ln[0]);
    stg_d.ln[1] = lane_step(stg_i.ln[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

// ===== sv/cau_refill.sv =====
`timescale 1ns / 1ps

module cau_refill #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  cau_pkg::stg_t stg_i,
  output logic          vld_o,
  output cau_pkg::stg_t stg_o
);
  import cau_pkg::*;

  // radicand (m +- ar) * 2^(F-1) is left aligned on an even bit count
  localparam int S2     = (CAU_DW + FRAC_BITS + 1) / 2;
  localparam int SRC_SH = FRAC_BITS - 1 + CAU_PW - 2 * S2;

  logic                   vld_q;
  stg_t                   stg_q, stg_d;
  logic signed [CAU_DW+1:0] mod_s, ar_s, tp, tm;

  always_comb begin
    mod_s = signed'({2'b00, stg_i.ln[0].acc});
    ar_s  = (CAU_DW+2)'(stg_i.ctx.ar);
    tp    = mod_s + ar_s;
    tm    = mod_s - ar_s;
    stg_d = stg_i;
    if (stg_i.ctx.op == CMD_SQRT) begin
      stg_d.ln[0]     = '0;
      stg_d.ln[0].run = 1'b1;
      stg_d.ln[0].sqr = 1'b1;
      stg_d.ln[0].src = dword_t'(tp[CAU_DW:0]) << SRC_SH;
      stg_d.ln[1]     = '0;
      stg_d.ln[1].run = 1'b1;
      stg_d.ln[1].sqr = 1'b1;
      stg_d.ln[1].src = dword_t'(tm[CAU_DW:0]) << SRC_SH;
    end else begin
      // quotients are complete; park the lanes for the second row
      stg_d.ln[0].run = 1'b0;
      stg_d.ln[1].run = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

// ===== sv/cau_back.sv =====
`timescale 1ns / 1ps

module cau_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  cau_pkg::stg_t stg_i,
  output logic          en_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cau_pkg::rsp_t out_o
);
  import cau_pkg::*;

  rsp_t            rsp;
  logic [CAU_DW:0] r1, r2;
  rsp_t            buf_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  // final saturation and status
  always_comb begin
    r1 = {1'b0, stg_i.ctx.res_re};
    r2 = {1'b0, stg_i.ctx.res_im};
    unique case (stg_i.ctx.op)
      CMD_DIV: begin
        if (stg_i.ctx.dz) begin
          r1 = '0;
          r2 = '0;
        end else begin
          r1 = clamp_mag(stg_i.ctx.n1,
                         stg_i.ctx.ovf1 ? '1 : CAU_MW'(stg_i.ln[0].acc));
          r2 = clamp_mag(stg_i.ctx.n2,
                         stg_i.ctx.ovf2 ? '1 : CAU_MW'(stg_i.ln[1].acc));
        end
      end
      CMD_SQRT: begin
        r1 = clamp_mag(1'b0, CAU_MW'(stg_i.ln[0].acc));
        r2 = clamp_mag(stg_i.ctx.ai_neg, CAU_MW'(stg_i.ln[1].acc));
      end
      default: ;
    endcase
    rsp.res_re   = r1[CAU_DW-1:0];
    rsp.res_im   = r2[CAU_DW-1:0];
    rsp.is_equal = stg_i.ctx.eq;
    if (stg_i.ctx.op == CMD_DIV && stg_i.ctx.dz) begin
      rsp.status = STS_DZ;
    end else if (stg_i.ctx.sat || r1[CAU_DW] || r2[CAU_DW]) begin
      rsp.status = STS_SAT;
    end else begin
      rsp.status = STS_OK;
    end
  end

  // two-entry output queue; the pipeline moves while it has room
  assign en_o        = (cnt_q != 2'd2);
  assign push        = en_o && vld_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = buf_q[rd_q];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= rsp;
  end

endmodule

// ===== sv/complex_arith_unit.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake     | Payload
// req_i   | in  | valid / ready | cmd[3:0], a_re, a_im, b_re, b_im (signed Q16.16)
// rsp_o   | out | valid / ready | res_re, res_im (signed Q16.16), is_equal, status[1:0]
//
// One transaction per cycle sustained while the output queue has room. Most of the
// pipeline is the two rows of compare-subtract cells, which at Q16.16 are 32 for
// the quotient and modulus root, then one per bit pair of the final roots.
// rst_ni clears the pipeline valid bits and the output queue; nothing else.
// A stalled output fills a two-entry queue; req_i.ready drops only when it is full.

module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_req_if.sink   req_i,
  cau_rsp_if.source rsp_o
);
  import cau_pkg::*;

  localparam int S2 = (CAU_DW + FRAC_BITS + 1) / 2;   // cells in the second row

  logic          en;
  logic [CAU_DW:0] v1;
  stg_t          s1 [CAU_DW+1];
  logic [S2:0]   v2;
  stg_t          s2 [S2+1];
  rsp_t          rsp;

  assign req_i.ready = en;

  // multiply, sum, round and lane setup
  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (req_i.valid),
    .cmd_i  (req_i.cmd),
    .a_re_i (req_i.a_re),
    .a_im_i (req_i.a_im),
    .b_re_i (req_i.b_re),
    .b_im_i (req_i.b_im),
    .vld_o  (v1[0]),
    .stg_o  (s1[0])
  );

  // first row: quotient bits, or the modulus root
  for (genvar g = 0; g < CAU_DW; g++) begin : g_row1
    cau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (v1[g]),
      .stg_i  (s1[g]),
      .vld_o  (v1[g+1]),
      .stg_o  (s1[g+1])
    );
  end

  // square root: seed both lanes with (m + ar) and (m - ar)
  cau_refill #(.FRAC_BITS(FRAC_BITS)) u_refill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v1[CAU_DW]),
    .stg_i  (s1[CAU_DW]),
    .vld_o  (v2[0]),
    .stg_o  (s2[0])
  );

  // second row: real and imaginary roots; idle lanes pass through
  for (genvar g = 0; g < S2; g++) begin : g_row2
    cau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (v2[g]),
      .stg_i  (s2[g]),
      .vld_o  (v2[g+1]),
      .stg_o  (s2[g+1])
    );
  end

  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (v2[S2]),
    .stg_i       (s2[S2]),
    .en_o        (en),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_o       (rsp)
  );

  assign rsp_o.res_re   = rsp.res_re;
  assign rsp_o.res_im   = rsp.res_im;
  assign rsp_o.is_equal = rsp.is_equal;
  assign rsp_o.status   = rsp.status;

endmodule

// ===== sv/cau_chk.sv =====
`timescale 1ns / 1ps

module cau_chk (
  input logic       clk_i,
  input logic       rst_ni,
  cau_req_if.sink   req_i,
  cau_rsp_if.source rsp_o
);
  import cau_pkg::*;

  logic [7:0] pend_q;
  logic       acc_in, acc_out;

  assign acc_in  = req_i.valid && req_i.ready;
  assign acc_out = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {7'd0, acc_in} - {7'd0, acc_out};
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.res_re) &&
      $stable(rsp_o.res_im) && $stable(rsp_o.status) && $stable(rsp_o.is_equal))
    else $error("response changed while stalled");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == STS_DZ |->
      rsp_o.res_re == '0 && rsp_o.res_im == '0 && !rsp_o.is_equal)
    else $error("divide by zero with nonzero result");

  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.is_equal |->
      rsp_o.res_re == '0 && rsp_o.res_im == '0 && rsp_o.status == STS_OK)
    else $error("equal flag with nonzero result or status");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> pend_q != '0)
    else $error("response without a pending transaction");

endmodule

bind complex_arith_unit cau_chk u_cau_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cau_pkg::*;

  localparam int LATENCY = 61;

  logic clk;
  logic rst_ni;

  cau_req_if req ();
  cau_rsp_if rsp ();

  complex_arith_unit dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  rsp_t pending_results[$];
  int   n_errors;
  int   n_sent;
  int   n_checked;
  int   n_by_cmd[16];
  bit   idle_on;
  int   hold_left;      // long receiver hold-off, counted down by the receiver
  int   rx_idle_left;

  // ---------------------------------------------------------------------------
  // Predictor: exact wide-integer arithmetic, then saturation to one word.
  // ---------------------------------------------------------------------------
  typedef logic signed [127:0] wide_t;

  function automatic word_t sat_word(input wide_t v, inout logic sat);
    if (v > wide_t'(WORD_MAX)) begin
      sat = 1'b1;
      return WORD_MAX;
    end
    if (v < wide_t'(WORD_MIN)) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v[CAU_DW-1:0]);
  endfunction

  // Floor of the square root, digit by digit; operands here stay below 2^66.
  function automatic wide_t int_sqrt(input wide_t n);
    wide_t r;
    wide_t t;
    r = 0;
    for (int k = 33; k >= 0; k--) begin
      t = r | (wide_t'(1) <<< k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic rsp_t complex_result(input logic [3:0] cmd, input word_t a_re,
                                          input word_t a_im, input word_t b_re,
                                          input word_t b_im);
    rsp_t  r;
    wide_t ar, ai, br, bi, den, m, tp, tm, sr, si;
    logic  sat, dz, eq;
    ar = a_re; ai = a_im; br = b_re; bi = b_im;
    sat = 1'b0; dz = 1'b0; eq = 1'b0;
    r.res_re = '0;
    r.res_im = '0;
    case (cmd)
      CMD_ADD: begin
        r.res_re = sat_word(ar + br, sat);
        r.res_im = sat_word(ai + bi, sat);
      end
      CMD_SUB: begin
        r.res_re = sat_word(ar - br, sat);
        r.res_im = sat_word(ai - bi, sat);
      end
      CMD_MUL: begin
        // arithmetic shift floors the Q32 product sum to Q16
        r.res_re = sat_word((ar * br - ai * bi) >>> CAU_FRAC_BITS, sat);
        r.res_im = sat_word((ar * bi + ai * br) >>> CAU_FRAC_BITS, sat);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          dz = 1'b1;
        end else begin
          // signed division truncates toward zero
          r.res_re = sat_word(((ar * br + ai * bi) <<< CAU_FRAC_BITS) / den, sat);
          r.res_im = sat_word(((ai * br - ar * bi) <<< CAU_FRAC_BITS) / den, sat);
        end
      end
      CMD_NEG: begin
        r.res_re = sat_word(-ar, sat);
        r.res_im = sat_word(-ai, sat);
      end
      CMD_CONJ: begin
        r.res_re = a_re;
        r.res_im = sat_word(-ai, sat);
      end
      CMD_SQRT: begin
        m  = int_sqrt(ar * ar + ai * ai);
        tp = m + ar;
        tm = m - ar;
        sr = int_sqrt(tp <<< (CAU_FRAC_BITS - 1));
        si = int_sqrt(tm <<< (CAU_FRAC_BITS - 1));
        r.res_re = sat_word(sr, sat);
        r.res_im = sat_word((ai < 0) ? -si : si, sat);
      end
      CMD_NORM2: begin
        r.res_re = sat_word((ar * ar + ai * ai) >>> CAU_FRAC_BITS, sat);
      end
      CMD_EQUAL: begin
        eq = (a_re == b_re) && (a_im == b_im);
      end
      default: begin
      end
    endcase
    r.is_equal = eq;
    r.status   = dz ? STS_DZ : (sat ? STS_SAT : STS_OK);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after accept.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [3:0] cmd, input word_t a_re, input word_t a_im,
                           input word_t b_re, input word_t b_im);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= cmd;
    req.a_re  <= a_re;
    req.a_im  <= a_im;
    req.b_re  <= b_re;
    req.b_im  <= b_im;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(complex_result(cmd, a_re, a_im, b_re, b_im));
    n_sent++;
    n_by_cmd[cmd]++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // Receiver: random stall bursts plus an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else if (rx_idle_left > 0) begin
      rx_idle_left <= rx_idle_left - 1;
      rsp.ready    <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_idle_left <= $urandom_range(0, 9);
      rsp.ready    <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", n_checked, what, got, want);
    n_errors++;
  endtask

  // Checker: each response transaction against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("response transaction with no prediction pending");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.res_re !== want.res_re) report_mismatch("res_re", rsp.res_re, want.res_re);
        if (rsp.res_im !== want.res_im) report_mismatch("res_im", rsp.res_im, want.res_im);
        if (rsp.is_equal !== want.is_equal)
          report_mismatch("is_equal", rsp.is_equal, want.is_equal);
        if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
      end
      n_checked++;
    end
  end

  // Operand mix: full-range, small Q16.16 values, and edge values.
  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0, 1: return word_t'($urandom);
      2, 3: return word_t'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      4: return word_t'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
      default: begin
        case ($urandom_range(0, 5))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          3: return word_t'(1);
          4: return word_t'(-1);
          default: return word_t'(32'h0001_0000);
        endcase
      end
    endcase
  endfunction

  task automatic send_random();
    logic [3:0] cmd;
    word_t ar, ai, br, bi;
    cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    ar = rand_word(); ai = rand_word(); br = rand_word(); bi = rand_word();
    // steer some cases that random operands rarely hit
    if (cmd == CMD_DIV && $urandom_range(0, 7) == 0) begin
      br = '0; bi = '0;
    end
    if (cmd == CMD_EQUAL && $urandom_range(0, 1) == 0) begin
      br = ar;
      bi = ($urandom_range(0, 2) == 0) ? ai ^ (32'h1 << $urandom_range(0, 31)) : ai;
    end
    send_item(cmd, ar, ai, br, bi);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_item(CMD_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);   // both parts saturate
    send_item(CMD_ADD, 32'h0001_0000, -32'sh0002_0000, 32'h0000_8000, 32'h0);
    send_item(CMD_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
    send_item(CMD_SUB, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(CMD_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_item(CMD_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_item(CMD_MUL, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000); // i*i = -1
    send_item(CMD_MUL, -32'sh1, 32'h0, 32'h1, 32'h0);               // floor of tiny negative
    send_item(CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0); // divide by zero
    send_item(CMD_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
    send_item(CMD_DIV, WORD_MAX, WORD_MIN, 32'h1, 32'h0);           // quotient overflow
    send_item(CMD_DIV, -32'sh0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    send_item(CMD_NEG, WORD_MIN, WORD_MIN, 32'h0, 32'h0);           // negate most negative
    send_item(CMD_NEG, 32'h0, WORD_MAX, 32'h0, 32'h0);
    send_item(CMD_CONJ, WORD_MIN, WORD_MIN, 32'h0, 32'h0);
    send_item(CMD_SQRT, -32'sh0004_0000, 32'h0, 32'h0, 32'h0);
    send_item(CMD_SQRT, 32'h0004_0000, 32'h0, 32'h0, 32'h0);
    send_item(CMD_SQRT, WORD_MIN, WORD_MIN, 32'h0, 32'h0);
    send_item(CMD_SQRT, 32'h0, -32'sh0002_0000, 32'h0, 32'h0);
    send_item(CMD_NORM2, WORD_MIN, WORD_MIN, 32'h0, 32'h0);         // saturates
    send_item(CMD_NORM2, 32'h0003_0000, -32'sh0004_0000, 32'h0, 32'h0);
    send_item(CMD_EQUAL, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    send_item(CMD_EQUAL, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN);
    send_item(4'd9, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);        // unknown opcodes
    send_item(4'd15, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random();
  endtask

  // Receiver holds off long enough to fill the pipe; sender keeps offering.
  task automatic test_backpressure();
    hold_left = 400;
    repeat (100) send_random();
  endtask

  // Sender pauses until every prediction has been matched, then resumes.
  task automatic test_drain_pause();
    wait_drained();
    repeat (50) send_random();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    repeat (150) send_random();
  endtask

  initial begin
    n_errors = 0; n_sent = 0; n_checked = 0;
    hold_left = 0; rx_idle_left = 0;
    idle_on = 1'b1;
    foreach (n_by_cmd[k]) n_by_cmd[k] = 0;
    req.valid = 1'b0;
    req.cmd   = '0;
    req.a_re  = '0;
    req.a_im  = '0;
    req.b_re  = '0;
    req.b_im  = '0;
    rsp.ready = 1'b0;
    rst_ni    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(350);
    test_backpressure();
    test_drain_pause();
    test_random(100);
    test_streaming();

    wait_drained();
    $display("%0d transactions sent, %0d checked; add %0d sub %0d mul %0d div %0d",
             n_sent, n_checked, n_by_cmd[0], n_by_cmd[1], n_by_cmd[2], n_by_cmd[3]);
    $display("neg %0d conj %0d sqrt %0d norm2 %0d equal %0d, with stalls and a full-pipe hold",
             n_by_cmd[4], n_by_cmd[5], n_by_cmd[6], n_by_cmd[7], n_by_cmd[8]);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("[complex_arith_unit] OK");
    end else begin
      $display("[complex_arith_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d predictions pending", pending_results.size());
    $display("[complex_arith_unit] ERROR");
    $finish;
  end

endmodule

// ===== complex_arith_unit.f =====
sv/cau_pkg.sv
sv/cau_if.sv
sv/cau_front.sv
sv/cau_cell.sv
sv/cau_refill.sv
sv/cau_back.sv
sv/complex_arith_unit.sv
sv/cau_chk.sv
test/tb.sv
